@@ sv/gsrc_pkg.sv @@
// ----------------------------------------------------------------------------
// gsrc_pkg
// Shared types and constants for the gas sensor reply checker: frame layout,
// configuration register indexes, result status codes and register resets.
// ----------------------------------------------------------------------------
package gsrc_pkg;

	localparam int unsigned CFG_INDEX_W = 8;
	localparam int unsigned CFG_DATA_W  = 16;

	localparam logic [7:0] HEADER_BYTE = 8'hFF;
	localparam logic [3:0] FRAME_LAST  = 4'd8;
	localparam logic [3:0] IDX_IDLE    = 4'd0;
	localparam logic [3:0] IDX_ECHO    = 4'd1;
	localparam logic [3:0] IDX_HIGH    = 4'd2;
	localparam logic [3:0] IDX_LOW     = 4'd3;

	// Configuration register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_MIN_PLAUSIBLE = 8'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_MAX_PLAUSIBLE = 8'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_MAX_JUMP      = 8'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_REPLY_COMMAND = 8'd3;

	// Register reset values
	localparam logic [15:0] MIN_PLAUSIBLE_RST = 16'd400;
	localparam logic [15:0] MAX_PLAUSIBLE_RST = 16'd5000;
	localparam logic [15:0] MAX_JUMP_RST      = 16'd500;
	localparam logic [7:0]  REPLY_COMMAND_RST = 8'h86;

	localparam logic [15:0] REJECT_READING = 16'd1;

	typedef enum logic [1:0] {
		ST_GOOD     = 2'd0,
		ST_FALLBACK = 2'd1,
		ST_REJECT   = 2'd2
	} status_t;

endpackage

@@ sv/gas_sensor_reply_checker_top.sv @@
// ----------------------------------------------------------------------------
// gas_sensor_reply_checker_top
// Checks a gas sensor's nine-byte reply and emits its reading and status.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready): one item per received byte, rx_byte
//   with frame_start high on byte 0 of a reply. A start always opens a new
//   frame and drops any partial one; bytes outside a frame are ignored.
//   Output channel (out_valid/out_ready): one item per completed frame, on
//   the ninth byte: reading and status (good checksum, plausibility
//   fallback, or rejected with reading 1).
//   Config channel (cfg_valid/cfg_ready): always ready; cfg_index selects
//   min_plausible, max_plausible, max_jump or reply_command. Other indexes
//   are ignored. Write only while no frame is in flight.
// Latency and throughput:
//   One byte is accepted every cycle unless stalled as below. The result is
//   loaded into the output register at the edge that accepts the checksum
//   byte and is offered from the next cycle on. The per-byte update (8-bit
//   add, header/echo compares, 16-bit range and jump compares on byte 8)
//   sits between the frame state and the output register.
// Stall:
//   A waiting result holds the output register. While the checksum byte is
//   due, the next byte (checksum or a new start) waits for the register to
//   drain; every other byte is still taken.
// Reset:
//   arst_n clears frame state, the previous reading and the output valid,
//   and restores the configuration registers to their defaults.
// ----------------------------------------------------------------------------
module gas_sensor_reply_checker_top (
	input  logic                               clk,
	input  logic                               arst_n,
	// byte input
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [7:0]                         rx_byte,
	input  logic                               frame_start,
	// result output
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [15:0]                        reading,
	output gsrc_pkg::status_t                  status,
	// configuration writes
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [gsrc_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [gsrc_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import gsrc_pkg::*;

	// configuration
	logic [15:0] min_plausible_q;
	logic [15:0] max_plausible_q;
	logic [15:0] max_jump_q;
	logic [7:0]  reply_command_q;

	// frame state
	logic [3:0]  byte_index_q;
	logic [7:0]  running_sum_q;
	logic        header_ok_q;
	logic [7:0]  reading_high_q;
	logic [7:0]  reading_low_q;
	logic [15:0] previous_reading_q;

	// result register
	logic        out_valid_q;
	logic [15:0] reading_q;
	status_t     status_q;

	logic        in_acc;
	logic        cfg_acc;
	logic        is_last;
	logic        in_frame;
	logic [15:0] rd;
	logic [15:0] diff;
	logic [7:0]  expect_sum;
	logic        sum_ok;
	logic        fallback_ok;
	logic        res_take;
	status_t     res_status;
	logic [15:0] res_reading;

	// Hold the byte due as checksum back while an untaken result fills the register.
	assign in_ready  = !out_valid_q || out_ready || (byte_index_q != FRAME_LAST);
	assign in_acc    = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign cfg_acc   = cfg_valid && cfg_ready;

	assign in_frame  = (byte_index_q != IDX_IDLE) && (byte_index_q <= FRAME_LAST);
	assign is_last   = !frame_start && (byte_index_q == FRAME_LAST);

	// Checksum and plausibility on the ninth byte
	assign rd          = {reading_high_q, reading_low_q};
	assign diff        = (rd >= previous_reading_q) ? (rd - previous_reading_q)
	                                                : (previous_reading_q - rd);
	assign expect_sum  = 8'(~running_sum_q + 8'd1);
	assign sum_ok      = header_ok_q && (rx_byte == expect_sum);
	assign fallback_ok = (rx_byte == 8'd0) && (rd >= min_plausible_q)
	                     && (rd <= max_plausible_q) && (diff <= max_jump_q);

	always_comb begin
		res_take    = 1'b1;
		res_status  = ST_REJECT;
		res_reading = REJECT_READING;
		if (sum_ok) begin
			res_status  = ST_GOOD;
			res_reading = rd;
		end else if (fallback_ok) begin
			res_status  = ST_FALLBACK;
			res_reading = rd;
		end else begin
			res_take = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_plausible_q    <= MIN_PLAUSIBLE_RST;
			max_plausible_q    <= MAX_PLAUSIBLE_RST;
			max_jump_q         <= MAX_JUMP_RST;
			reply_command_q    <= REPLY_COMMAND_RST;
			byte_index_q       <= IDX_IDLE;
			running_sum_q      <= 8'd0;
			header_ok_q        <= 1'b0;
			reading_high_q     <= 8'd0;
			reading_low_q      <= 8'd0;
			previous_reading_q <= 16'd0;
			out_valid_q        <= 1'b0;
		end else begin
			if (cfg_acc) begin
				case (cfg_index)
					REG_MIN_PLAUSIBLE: min_plausible_q <= cfg_data;
					REG_MAX_PLAUSIBLE: max_plausible_q <= cfg_data;
					REG_MAX_JUMP:      max_jump_q      <= cfg_data;
					REG_REPLY_COMMAND: reply_command_q <= cfg_data[7:0];
					default: ;
				endcase
			end

			// drop the result once taken; a new one below overrides
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end

			if (in_acc) begin
				if (frame_start) begin
					header_ok_q   <= (rx_byte == HEADER_BYTE);
					running_sum_q <= 8'd0;
					byte_index_q  <= IDX_ECHO;
				end else if (!in_frame) begin
					byte_index_q <= IDX_IDLE;
				end else if (byte_index_q < FRAME_LAST) begin
					running_sum_q <= running_sum_q + rx_byte;
					if (byte_index_q == IDX_ECHO && rx_byte != reply_command_q) begin
						header_ok_q <= 1'b0;
					end
					if (byte_index_q == IDX_HIGH) begin
						reading_high_q <= rx_byte;
					end
					if (byte_index_q == IDX_LOW) begin
						reading_low_q <= rx_byte;
					end
					byte_index_q <= byte_index_q + 4'd1;
				end else begin
					// checksum byte: close the frame, emit one item
					byte_index_q <= IDX_IDLE;
					out_valid_q  <= 1'b1;
					if (res_take) begin
						previous_reading_q <= rd;
					end
				end
			end
		end
	end

	// result payload, loaded with the checksum byte
	always_ff @(posedge clk) begin
		if (in_acc && is_last) begin
			reading_q <= res_reading;
			status_q  <= res_status;
		end
	end

	assign out_valid = out_valid_q;
	assign reading   = reading_q;
	assign status    = status_q;

endmodule

@@ sv/gsrc_checker.sv @@
// ----------------------------------------------------------------------------
// gsrc_checker
// Port-level checks for the gas sensor reply checker, bound to the top level.
// ----------------------------------------------------------------------------
module gsrc_checker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	input  logic                               in_ready,
	input  logic                               out_valid,
	input  logic                               out_ready,
	input  logic [15:0]                        reading,
	input  gsrc_pkg::status_t                  status
);
	import gsrc_pkg::*;

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(reading) && $stable(status))
		else $error("result changed while stalled");

	// rejected frames report reading 1
	a_reject_value: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_REJECT |-> reading == REJECT_READING)
		else $error("rejected frame with reading other than 1");

	// only defined status codes leave the block
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status == ST_GOOD || status == ST_FALLBACK || status == ST_REJECT)
		else $error("undefined status code");

	// a result comes only from a byte accepted the cycle before
	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		(!out_valid || out_ready) && !(in_valid && in_ready) |=> !out_valid)
		else $error("result without a new byte");

endmodule

bind gas_sensor_reply_checker_top gsrc_checker u_gsrc_checker (.*);

@@ tb/tb_gas_sensor_reply_checker_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_gas_sensor_reply_checker_top
// Self-checking bench for the gas sensor reply checker. Bytes of nine-byte
// replies (good, zero-checksum, corrupted, cut short, stray) are pushed in
// under varying input gaps and output stalls, through several register
// settings. An in-bench model of the frame logic predicts every result and
// the result port is compared field by field against it.
// ----------------------------------------------------------------------------
module tb_gas_sensor_reply_checker_top;

	import gsrc_pkg::*;

	localparam int WATCHDOG_LIMIT  = 2000;
	localparam int PHASES          = 8;
	localparam int ITEMS_PER_PHASE = 180;
	localparam int DRAIN_CYCLES    = 4;

	typedef struct packed {
		logic [15:0] reading;
		status_t     status;
	} reply_t;

	// Kinds of byte sequence the stimulus can produce
	typedef enum int {
		FK_GOOD,
		FK_FALLBACK,
		FK_BAD_SUM,
		FK_BAD_HEADER,
		FK_BAD_ECHO,
		FK_CUT,
		FK_STRAY
	} frame_kind_t;

	// Frame model plus the queue of readings it still expects
	class reading_scoreboard;
		logic [15:0] min_ok, max_ok, jump_limit;
		logic [7:0]  echo_cmd;
		logic [3:0]  pos;
		logic [7:0]  sum;
		logic        hdr_good;
		logic [7:0]  rd_hi, rd_lo;
		logic [15:0] last_good;
		reply_t      expected_q[$];
		int unsigned errors;

		function new();
			min_ok     = MIN_PLAUSIBLE_RST;
			max_ok     = MAX_PLAUSIBLE_RST;
			jump_limit = MAX_JUMP_RST;
			echo_cmd   = REPLY_COMMAND_RST;
			pos        = IDX_IDLE;
			sum        = '0;
			hdr_good   = 1'b0;
			rd_hi      = '0;
			rd_lo      = '0;
			last_good  = '0;
			errors     = 0;
		endfunction

		function void set_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_MIN_PLAUSIBLE: min_ok = data;
				REG_MAX_PLAUSIBLE: max_ok = data;
				REG_MAX_JUMP:      jump_limit = data;
				REG_REPLY_COMMAND: echo_cmd = data[7:0];
				default: ;
			endcase
		endfunction

		function void note_byte(logic [7:0] b, logic start);
			logic [7:0]  want;
			logic [15:0] rd;
			logic [15:0] diff;
			reply_t      res;
			if (start) begin
				hdr_good = (b == HEADER_BYTE);
				sum      = '0;
				pos      = IDX_ECHO;
				return;
			end
			if (pos == IDX_IDLE || pos > FRAME_LAST) begin
				pos = IDX_IDLE;
				return;
			end
			if (pos < FRAME_LAST) begin
				sum = sum + b;
				if (pos == IDX_ECHO && b != echo_cmd)
					hdr_good = 1'b0;
				if (pos == IDX_HIGH)
					rd_hi = b;
				if (pos == IDX_LOW)
					rd_lo = b;
				pos = pos + 4'd1;
				return;
			end
			want = 8'd0 - sum;
			rd   = {rd_hi, rd_lo};
			diff = (rd >= last_good) ? rd - last_good : last_good - rd;
			if (hdr_good && b == want) begin
				res       = '{reading: rd, status: ST_GOOD};
				last_good = rd;
			end else if (b == 8'd0 && rd >= min_ok && rd <= max_ok && diff <= jump_limit) begin
				res       = '{reading: rd, status: ST_FALLBACK};
				last_good = rd;
			end else begin
				res = '{reading: REJECT_READING, status: ST_REJECT};
			end
			pos = IDX_IDLE;
			expected_q.push_back(res);
		endfunction

		function void check_reading(logic [15:0] rd, logic [1:0] st);
			reply_t exp;
			if (expected_q.size() == 0) begin
				$error("unexpected result: reading %0d status %0d", rd, st);
				errors++;
				return;
			end
			exp = expected_q.pop_front();
			if (rd !== exp.reading) begin
				$error("reading: expected %0d, got %0d", exp.reading, rd);
				errors++;
			end
			if (st !== exp.status) begin
				$error("status: expected %0d, got %0d", exp.status, st);
				errors++;
			end
		endfunction
	endclass

	// Clock, reset and block ports; every input starts at a known value
	logic                   clk         = 1'b0;
	logic                   arst_n      = 1'b0;
	logic                   in_valid    = 1'b0;
	logic                   in_ready;
	logic [7:0]             rx_byte     = '0;
	logic                   frame_start = 1'b0;
	logic                   out_valid;
	logic                   out_ready   = 1'b0;
	logic [15:0]            reading;
	status_t                status;
	logic                   cfg_valid   = 1'b0;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index   = '0;
	logic [CFG_DATA_W-1:0]  cfg_data    = '0;

	reading_scoreboard sb;
	int                send_idle_pct  = 0;
	int                recv_stall_pct = 0;
	int                idle_cycles    = 0;

	always #10 clk = ~clk;

	gas_sensor_reply_checker_top uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.rx_byte     (rx_byte),
		.frame_start (frame_start),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.reading     (reading),
		.status      (status),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	// Receiver: stall at random according to the current profile
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Check every result taken from the output port
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_reading(reading, status);
	end

	// Watchdog: give up once nothing has moved on any channel for too long
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Offer one byte and hold it until taken. Valid is left high so that the
	// next byte can follow back to back; the caller drops it when done.
	task automatic send_byte(input logic [7:0] b, input logic s);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		rx_byte     <= b;
		frame_start <= s;
		do
			@(posedge clk);
		while (!in_ready);
		sb.note_byte(b, s);
	endtask

	// Write one register; valid stays high for a following write
	task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do
			@(posedge clk);
		while (!cfg_ready);
		sb.set_register(idx, data);
	endtask

	// Choose a reading that lands near the interesting boundaries
	function automatic logic [15:0] pick_reading();
		logic [15:0] off;
		case ($urandom_range(7))
			0: return 16'($urandom_range(16'hFFFF));
			1: return sb.last_good + sb.jump_limit + 16'($urandom_range(2)) - 16'd1;
			2: return sb.last_good - sb.jump_limit + 16'($urandom_range(2)) - 16'd1;
			3: return sb.min_ok + 16'($urandom_range(2)) - 16'd1;
			4: return sb.max_ok + 16'($urandom_range(2)) - 16'd1;
			5: return $urandom_range(1) ? 16'hFFFF : 16'h0000;
			default: begin
				off = 16'($urandom_range(sb.jump_limit));
				return $urandom_range(1) ? sb.last_good + off : sb.last_good - off;
			end
		endcase
	endfunction

	// Build a reply of the given kind around a reading and send its first
	// count bytes; returns the number of bytes sent
	task automatic send_frame(input frame_kind_t kind, input logic [15:0] rd,
			input int count, output int sent);
		logic [7:0] fb[9];
		logic [7:0] s;
		int         i;
		fb[0] = HEADER_BYTE;
		fb[1] = sb.echo_cmd;
		fb[2] = rd[15:8];
		fb[3] = rd[7:0];
		for (i = 4; i < 8; i++)
			fb[i] = 8'($urandom_range(255));
		if (kind == FK_BAD_HEADER)
			fb[0] = 8'($urandom_range(254));
		if (kind == FK_BAD_ECHO)
			fb[1] = sb.echo_cmd ^ 8'($urandom_range(255, 1));
		s = '0;
		for (i = 1; i < 8; i++)
			s = s + fb[i];
		fb[8] = 8'd0 - s;
		case (kind)
			FK_BAD_SUM: fb[8] = fb[8] ^ 8'($urandom_range(255, 1));
			FK_FALLBACK: fb[8] = 8'd0;
			// broken header or echo: sometimes give the fallback a chance
			FK_BAD_HEADER, FK_BAD_ECHO: if ($urandom_range(2) == 0) fb[8] = 8'd0;
			default: ;
		endcase
		for (i = 0; i < count; i++)
			send_byte(fb[i], i == 0);
		sent = count;
	endtask

	task automatic run_directed();
		int n;
		send_byte(8'h55, 1'b0);                    // byte outside any frame
		send_frame(FK_BAD_HEADER, 16'd450, 9, n);  // may fall back on a zero sum
		send_frame(FK_FALLBACK, 16'd450, 9, n);    // within range and jump
		send_frame(FK_CUT, 16'hFFFF, 3, n);        // dropped by the next start
		send_frame(FK_GOOD, 16'hFFFF, 9, n);
		send_frame(FK_BAD_SUM, 16'h0000, 9, n);
	endtask

	task automatic run_random(input int quota);
		int          done;
		int          n;
		int          pick;
		frame_kind_t kind;
		done = 0;
		while (done < quota) begin
			pick = $urandom_range(99);
			if (pick < 30)      kind = FK_GOOD;
			else if (pick < 60) kind = FK_FALLBACK;
			else if (pick < 70) kind = FK_BAD_SUM;
			else if (pick < 78) kind = FK_BAD_HEADER;
			else if (pick < 86) kind = FK_BAD_ECHO;
			else if (pick < 95) kind = FK_CUT;
			else                kind = FK_STRAY;
			if (kind == FK_STRAY) begin
				// noise bytes; ignored unless a cut frame is still open
				repeat ($urandom_range(3, 1))
					send_byte(8'($urandom_range(255)), 1'b0);
			end else begin
				send_frame(kind, pick_reading(), (kind == FK_CUT) ? $urandom_range(8, 1) : 9, n);
				done += n;
			end
		end
	endtask

	// Close any open frame, drop valid, drain results and let the block settle
	task automatic settle();
		while (sb.pos != IDX_IDLE)
			send_byte(8'($urandom_range(255)), 1'b0);
		in_valid <= 1'b0;
		while (sb.expected_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic apply_settings(input int p);
		case (p)
			1: begin
				write_register(REG_MIN_PLAUSIBLE, 16'h0000);
				write_register(REG_MAX_PLAUSIBLE, 16'hFFFF);
				write_register(REG_MAX_JUMP, 16'hFFFF);
				write_register(REG_REPLY_COMMAND, {8'($urandom_range(255)), 8'h00});
			end
			2: begin
				// empty plausible range: the fallback never accepts
				write_register(REG_MIN_PLAUSIBLE, 16'hFFFF);
				write_register(REG_MAX_PLAUSIBLE, 16'h0000);
				write_register(REG_MAX_JUMP, 16'h0000);
				write_register(REG_REPLY_COMMAND, {8'($urandom_range(255)), 8'hFF});
			end
			3: begin
				write_register(REG_MIN_PLAUSIBLE, 16'd100);
				write_register(REG_MAX_PLAUSIBLE, 16'd200);
				write_register(REG_MAX_JUMP, 16'd0);
				write_register(REG_REPLY_COMMAND, {8'hA5, REPLY_COMMAND_RST});
			end
			4: begin
				write_register(REG_MIN_PLAUSIBLE, 16'd1000);
				write_register(REG_MAX_PLAUSIBLE, 16'd60000);
				write_register(REG_MAX_JUMP, 16'd20000);
				write_register(REG_REPLY_COMMAND, 16'($urandom_range(16'hFFFF)));
			end
			5: begin
				write_register(REG_MIN_PLAUSIBLE, 16'($urandom_range(16'hFFFF)));
				write_register(REG_MAX_PLAUSIBLE, 16'($urandom_range(16'hFFFF)));
				write_register(REG_MAX_JUMP, 16'($urandom_range(16'hFFFF)));
				write_register(REG_REPLY_COMMAND, 16'($urandom_range(16'hFFFF)));
			end
			6: begin
				write_register(REG_MIN_PLAUSIBLE, 16'd0);
				write_register(REG_MAX_PLAUSIBLE, 16'd0);
				write_register(REG_MAX_JUMP, 16'd0);
				write_register(REG_REPLY_COMMAND, 16'h0001);
			end
			default: begin
				write_register(REG_MIN_PLAUSIBLE, MIN_PLAUSIBLE_RST);
				write_register(REG_MAX_PLAUSIBLE, MAX_PLAUSIBLE_RST);
				write_register(REG_MAX_JUMP, MAX_JUMP_RST);
				write_register(REG_REPLY_COMMAND, {8'h00, REPLY_COMMAND_RST});
			end
		endcase
		// indexes past the last register must be ignored
		write_register(CFG_INDEX_W'($urandom_range(255, 4)), 16'($urandom_range(16'hFFFF)));
		cfg_valid <= 1'b0;
	endtask

	initial begin
		int p;
		sb = new();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (p = 0; p < PHASES; p++) begin
			if (p != 0)
				settle();
			// idling profile: none, sender gaps, receiver stalls, both
			case (p % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 62; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 62; end
				default: begin send_idle_pct = 37; recv_stall_pct = 37; end
			endcase
			if (p == 0)
				run_directed();
			else
				apply_settings(p);
			run_random(ITEMS_PER_PHASE);
		end
		settle();
		if (sb.errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

@@ files.f @@
sv/gsrc_pkg.sv
sv/gas_sensor_reply_checker_top.sv
sv/gsrc_checker.sv
tb/tb_gas_sensor_reply_checker_top.sv
